>>> sv/uue_pkg.sv
// ----------------------------------------------------------------------------
// uue_pkg
// Shared constants and types of the uuencode line encoder: line size
// default, character codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package uue_pkg;

    // default bytes per encoded line
    localparam int LINE_BYTES_DEF = 45;

    // character codes
    localparam logic [7:0] UU_BIAS     = 8'd32;
    localparam logic [7:0] UU_NEWLINE  = 8'd10;
    localparam logic [7:0] UU_BACKTICK = 8'd96;

    // input action codes (carried in tuser)
    localparam logic ACT_DATA   = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    // output character select codes
    localparam logic [1:0] SEL_LEN  = 2'd0;
    localparam logic [1:0] SEL_DATA = 2'd1;
    localparam logic [1:0] SEL_NL   = 2'd2;
    localparam logic [1:0] SEL_TICK = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic       wr_byte;    // store input byte, bump fill count
        logic       clr_count;  // line emitted, restart fill
        logic       grp_init;   // group base and step counters to zero
        logic       rd_step;    // one step of the three-byte group fetch
        logic       grp_next;   // advance group base by three
        logic       emit;       // load output register
        logic [1:0] emit_sel;   // which character to load
        logic       emit_last;  // final character of this input word
    } uue_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic line_full_next;   // the byte being written fills the line
        logic count_zero;       // no bytes buffered
        logic rd_done;          // group fetch finished
        logic char_done;        // fourth character of the group
        logic grp_last;         // current group is the last of the line
        logic slot_free;        // output register can take a word
    } uue_sts_t;

endpackage

`default_nettype wire

>>> sv/uue_datapath.sv
// ----------------------------------------------------------------------------
// uue_datapath
// Line buffer memory, fill count, group fetch and character formatting,
// plus the output register of the master-side stream.
// ----------------------------------------------------------------------------
`default_nettype none

module uue_datapath
    import uue_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire uue_cmd_t   cmd,
    output uue_sts_t        sts,
    input  wire logic [7:0] in_byte,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic [7:0]      out_char,
    output logic            out_last
);

    localparam int CNT_W  = $clog2(LINE_BYTES + 3);
    localparam int ADDR_W = $clog2(LINE_BYTES);

    localparam logic [CNT_W-1:0] LINE_FULL_M1 = CNT_W'(LINE_BYTES - 1);
    localparam logic [CNT_W-1:0] GRP_STEP     = CNT_W'(3);

    // line buffer, no reset: only written entries are read
    logic [7:0]       mem [LINE_BYTES];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] grp_reg, grp_next;
    logic [1:0]       step_reg, step_next;
    logic [1:0]       ci_reg, ci_next;
    logic [7:0]       rd_data_reg;
    logic             rd_ok_reg;
    logic [23:0]      group_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;

    logic [CNT_W-1:0] rd_pos;
    logic             rd_in_line;
    logic [5:0]       sextet;

    assign rd_pos     = grp_reg + CNT_W'(step_reg);
    assign rd_in_line = (rd_pos < count_reg);

    // memory write and group fetch read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
        begin
            mem[count_reg[ADDR_W-1:0]] <= in_byte;
        end
        if (cmd.rd_step && (step_reg != 2'd3) && rd_in_line)
        begin
            rd_data_reg <= mem[rd_pos[ADDR_W-1:0]];
        end
    end

    // fetch shift: byte read in one step is shifted in on the next
    always_ff @(posedge clk)
    begin
        if (cmd.rd_step)
        begin
            rd_ok_reg <= rd_in_line && (step_reg != 2'd3);
            if (step_reg != 2'd0)
            begin
                group_reg <= {group_reg[15:0], rd_ok_reg ? rd_data_reg : 8'd0};
            end
        end
    end

    // counters
    always_comb
    begin
        count_next = count_reg;
        grp_next   = grp_reg;
        step_next  = step_reg;
        ci_next    = ci_reg;
        if (cmd.wr_byte)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.clr_count)
        begin
            count_next = '0;
        end
        if (cmd.grp_init)
        begin
            grp_next  = '0;
            step_next = '0;
            ci_next   = '0;
        end
        if (cmd.rd_step)
        begin
            step_next = step_reg + 2'd1;
        end
        if (cmd.emit && (cmd.emit_sel == SEL_DATA))
        begin
            ci_next = ci_reg + 2'd1;
        end
        if (cmd.grp_next)
        begin
            grp_next = grp_reg + GRP_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            grp_reg   <= '0;
            step_reg  <= '0;
            ci_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            grp_reg   <= grp_next;
            step_reg  <= step_next;
            ci_reg    <= ci_next;
        end
    end

    // sextet of the current group, most significant first
    always_comb
    begin
        case (ci_reg)
            2'd0:    sextet = group_reg[23:18];
            2'd1:    sextet = group_reg[17:12];
            2'd2:    sextet = group_reg[11:6];
            default: sextet = group_reg[5:0];
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = cmd.emit_last;
            case (cmd.emit_sel)
                SEL_LEN:  out_char_next = UU_BIAS + 8'(count_reg);
                SEL_DATA: out_char_next = UU_BIAS + {2'b00, sextet};
                SEL_NL:   out_char_next = UU_NEWLINE;
                SEL_TICK: out_char_next = UU_BACKTICK;
                default:  out_char_next = UU_NEWLINE;
            endcase
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // status
    assign sts.line_full_next = (count_reg == LINE_FULL_M1);
    assign sts.count_zero     = (count_reg == '0);
    assign sts.rd_done        = (step_reg == 2'd3);
    assign sts.char_done      = (ci_reg == 2'd3);
    assign sts.grp_last       = ((grp_reg + GRP_STEP) >= count_reg);
    assign sts.slot_free      = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

>>> sv/uue_ctrl.sv
// ----------------------------------------------------------------------------
// uue_ctrl
// Sequencer of the uuencode line encoder: takes words, then walks a line
// through length, group fetch, data characters, newline and the end line.
// ----------------------------------------------------------------------------
`default_nettype none

module uue_ctrl
    import uue_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire logic     in_action,
    input  wire uue_sts_t sts,
    output uue_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LEN  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHR  = 3'd3;
    localparam logic [2:0] S_NL   = 3'd4;
    localparam logic [2:0] S_TICK = 3'd5;
    localparam logic [2:0] S_END  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       fin_reg, fin_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.grp_init = 1'b1;
                if (accept)
                begin
                    if (in_action == ACT_DATA)
                    begin
                        cmd.wr_byte = 1'b1;
                        fin_next    = 1'b0;
                        if (sts.line_full_next)
                        begin
                            state_next = S_LEN;
                        end
                    end
                    else
                    begin
                        fin_next   = 1'b1;
                        state_next = sts.count_zero ? S_TICK : S_LEN;
                    end
                end
            end
            S_LEN:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_LEN;
                    state_next   = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd_step = 1'b1;
                if (sts.rd_done)
                begin
                    state_next = S_CHR;
                end
            end
            S_CHR:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_DATA;
                    if (sts.char_done)
                    begin
                        cmd.grp_next = 1'b1;
                        state_next   = sts.grp_last ? S_NL : S_RD;
                    end
                end
            end
            S_NL:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_NL;
                    cmd.emit_last = !fin_reg;
                    cmd.clr_count = 1'b1;
                    state_next    = fin_reg ? S_TICK : S_IDLE;
                end
            end
            S_TICK:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_TICK;
                    state_next   = S_END;
                end
            end
            S_END:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = SEL_NL;
                    cmd.emit_last = 1'b1;
                    cmd.clr_count = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/uuencode_line_encoder.sv
// ----------------------------------------------------------------------------
// uuencode_line_encoder
// Buffers a byte stream into lines and emits the uuencoded line characters.
// ----------------------------------------------------------------------------
//  channel   dir  tdata            tuser        tlast
//  s_axis    in   data_byte[7:0]   action[0]    -
//  m_axis    out  out_char[7:0]    -            last_of_run
//
//  A data byte that does not fill the line is stored while the sequencer
//  stays idle. A full line emits the length character, then per group of
//  three bytes a fetch through the single registered line buffer read port
//  and four characters, then the newline; the end line adds a backtick line.
//  Reset clears the sequencer, fill count and output valid; the line
//  buffer is not cleared. A stalled m_axis_tready holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module uuencode_line_encoder
    import uue_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // data_byte[7:0]
    input  wire logic [0:0] s_axis_tuser,   // action[0]
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // out_char[7:0]
    output logic            m_axis_tlast
);

    uue_cmd_t cmd;
    uue_sts_t sts;

    // sequencer
    uue_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser[0]),
        .sts       (sts),
        .cmd       (cmd)
    );

    // line buffer and character formatting
    uue_datapath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_byte   (s_axis_tdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
